[src/air_sensor_validate_and_average_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the air sensor validate and average unit
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef AIR_SENSOR_VALIDATE_AND_AVERAGE_UNIT_ASSERT_SVH
`define AIR_SENSOR_VALIDATE_AND_AVERAGE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASVA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASVA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASVA_ASSERT(lbl, clk, rst, prop, msg)
`define ASVA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/asva_pkg.sv]
// ----------------------------------------------------------------------------
// Air sensor validate and average package
// Field widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asva_pkg;

   localparam int HDC_TEMP_W = 15;
   localparam int HUMID_W    = 14;
   localparam int VOC_TEMP_W = 16;
   localparam int WORD_W     = 16;
   localparam int FRAME_W    = 64;
   localparam int CO2_TEMP_W = 16;
   localparam int HELD_W     = 11;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int NUM_LANES       = 7;

   localparam int LANE_HDC_TEMP = 0;
   localparam int LANE_VOC_TEMP = 1;
   localparam int LANE_CO2_TEMP = 2;
   localparam int LANE_HUMIDITY = 3;
   localparam int LANE_CO2      = 4;
   localparam int LANE_ECO2     = 5;
   localparam int LANE_TVOC     = 6;

   localparam logic [15:0] EXCLUDED_PPM  = 16'd410;
   localparam logic [15:0] TVOC_NONE     = 16'hFFFF;
   localparam logic [9:0]  CO2_TEMP_BIAS = 10'd40;
   localparam logic signed [16:0] VOC_OFFSET_F = 17'sd5700;
   localparam logic [35:0] DIV9_RECIP    = 36'd233017;
   localparam logic signed [15:0] VOC_TEMP_MIN = -16'sd16384;
   localparam logic signed [15:0] VOC_TEMP_MAX = 16'sd16383;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef enum logic [1:0] {
      ASVA_IDLE,
      ASVA_DIV,
      ASVA_FIN,
      ASVA_DONE
   } asva_state_type;

endpackage

[src/asva_if.sv]
// ----------------------------------------------------------------------------
// Air sensor validate and average channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asva_req_if
   import asva_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [HDC_TEMP_W-1:0] hdc_temp;
   logic [HUMID_W-1:0]           hdc_humidity;
   logic                         voc_ok;
   logic signed [VOC_TEMP_W-1:0] voc_temp_f;
   logic [WORD_W-1:0]            tvoc_ppb;
   logic [WORD_W-1:0]            eco2_ppm;
   logic                         frame_seen;
   logic [FRAME_W-1:0]           co2_frame;

   modport source (output valid, op, hdc_temp, hdc_humidity, voc_ok, voc_temp_f,
                   tvoc_ppb, eco2_ppm, frame_seen, co2_frame, input ready);
   modport sink (input valid, op, hdc_temp, hdc_humidity, voc_ok, voc_temp_f,
                 tvoc_ppb, eco2_ppm, frame_seen, co2_frame, output ready);
endinterface

interface asva_rsp_if
   import asva_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic signed [HDC_TEMP_W-1:0] temp_hdc;
   logic signed [HDC_TEMP_W-1:0] temp_voc;
   logic signed [CO2_TEMP_W-1:0] temp_co2;
   logic [HUMID_W-1:0]           humidity;
   logic [WORD_W-1:0]            co2_ppm;
   logic [WORD_W-1:0]            eco2;
   logic [WORD_W-1:0]            tvoc;
   logic                         valid_res;
   logic [HELD_W-1:0]            samples_held;

   modport source (output valid, temp_hdc, temp_voc, temp_co2, humidity, co2_ppm,
                   eco2, tvoc, valid_res, samples_held, input ready);
   modport sink (input valid, temp_hdc, temp_voc, temp_co2, humidity, co2_ppm,
                 eco2, tvoc, valid_res, samples_held, output ready);
endinterface

[src/air_sensor_validate_and_average_unit.sv]
// ----------------------------------------------------------------------------
// Air sensor validate and average unit
// Validates combined air sensor samples and reports averages of valid ones.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on req_bus carries one op. A sample op checks the CO2 frame and
// the VOC reading, makes the readings current and adds them to running sums
// when the sample is valid, or clears the sums when it is not. A report op
// divides the seven sums by the sample count and makes the quotients current.
// Each op gives exactly one beat on rsp_bus with the current values.
// A sample op moves from the IDLE state to DONE and then into the response
// register. A report op with samples held runs through DIV, FIN and DONE;
// the sums are SUM_W = 17 + the count width bits wide (28 for 1024 samples),
// and seven restoring divider lanes give one quotient bit per cycle each.
// One op is in work at a time; the next is accepted once the previous has
// moved into the response register, so a stalled receiver holds one finished
// beat while one more op may be accepted and completed behind it.
// Reset clears the current values, the sums and the count and empties the
// response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module air_sensor_validate_and_average_unit
   import asva_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input logic       clock,
   input logic       reset,
   asva_req_if.sink   req_bus,
   asva_rsp_if.source rsp_bus
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = 17 + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   asva_state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SUM_W-1:0]  sum_ff [NUM_LANES];
   logic [SUM_W-1:0]  sum_in [NUM_LANES];
   logic [SUM_W-1:0]  quo_ff [NUM_LANES];
   logic [SUM_W-1:0]  quo_in [NUM_LANES];
   logic [CNT_W-1:0]  rem_ff [NUM_LANES];
   logic [CNT_W-1:0]  rem_in [NUM_LANES];
   logic              neg_ff [NUM_LANES];
   logic              neg_in [NUM_LANES];
   logic [SUM_W-1:0]  samp_ext [NUM_LANES];
   logic [SUM_W-1:0]  quo_step [NUM_LANES];
   logic [CNT_W-1:0]  rem_step [NUM_LANES];
   logic [SUM_W-1:0]  lane_res [NUM_LANES];

   logic [HDC_TEMP_W-1:0] cur_temp_hdc_ff, cur_temp_hdc_in;
   logic [HDC_TEMP_W-1:0] cur_temp_voc_ff, cur_temp_voc_in;
   logic [CO2_TEMP_W-1:0] cur_temp_co2_ff, cur_temp_co2_in;
   logic [HUMID_W-1:0]    cur_humidity_ff, cur_humidity_in;
   logic [WORD_W-1:0]     cur_co2_ff, cur_co2_in;
   logic [WORD_W-1:0]     cur_eco2_ff, cur_eco2_in;
   logic [WORD_W-1:0]     cur_tvoc_ff, cur_tvoc_in;
   logic                  cur_valid_ff, cur_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HDC_TEMP_W-1:0] out_temp_hdc_ff, out_temp_hdc_in;
   logic [HDC_TEMP_W-1:0] out_temp_voc_ff, out_temp_voc_in;
   logic [CO2_TEMP_W-1:0] out_temp_co2_ff, out_temp_co2_in;
   logic [HUMID_W-1:0]    out_humidity_ff, out_humidity_in;
   logic [WORD_W-1:0]     out_co2_ff, out_co2_in;
   logic [WORD_W-1:0]     out_eco2_ff, out_eco2_in;
   logic [WORD_W-1:0]     out_tvoc_ff, out_tvoc_in;
   logic                  out_valid_res_ff, out_valid_res_in;
   logic [HELD_W-1:0]     out_held_ff, out_held_in;

   logic req_ready;
   logic req_take;
   logic load_out;

   logic signed [16:0] voc_x;
   logic [18:0]        voc_x5;
   logic [18:0]        voc_neg5;
   logic               voc_neg;
   logic [17:0]        voc_mag;
   logic [35:0]        voc_prod;
   logic [15:0]        voc_q;
   logic signed [15:0] voc_c;
   logic [HDC_TEMP_W-1:0] voc_temp_c;

   logic [7:0]         fr_byte [8];
   logic [7:0]         fr_sum;
   logic               frame_good;
   logic [WORD_W-1:0]  level;
   logic signed [9:0]  co2_tb;
   logic signed [15:0] co2_temp;
   logic               sample_good;

   function automatic logic [16:0] voc_temp_f_ext(input logic [15:0] f);
      return {f[15], f};
   endfunction

   assign req_take = req_bus.valid && req_ready;

   // Sample datapath.
   always_comb begin
      voc_x      = $signed({voc_temp_f_ext(req_bus.voc_temp_f)}) - VOC_OFFSET_F;
      voc_x5     = {{2{voc_x[16]}}, voc_x} + {voc_x, 2'b00};
      voc_neg5   = -voc_x5;
      voc_neg    = voc_x5[18];
      voc_mag    = voc_neg ? voc_neg5[17:0] : voc_x5[17:0];
      voc_prod   = 36'(voc_mag) * DIV9_RECIP;
      voc_q      = {1'b0, voc_prod[35:21]};
      voc_c      = voc_neg ? $signed(-voc_q) : $signed(voc_q);
      if (voc_c < VOC_TEMP_MIN) begin
         voc_temp_c = VOC_TEMP_MIN[HDC_TEMP_W-1:0];
      end else if (voc_c > VOC_TEMP_MAX) begin
         voc_temp_c = VOC_TEMP_MAX[HDC_TEMP_W-1:0];
      end else begin
         voc_temp_c = voc_c[HDC_TEMP_W-1:0];
      end

      for (int k = 0; k < 8; k++) begin
         fr_byte[k] = req_bus.co2_frame[8*k +: 8];
      end
      fr_sum = 8'd0;
      for (int k = 0; k < 8; k++) begin
         fr_sum = fr_sum + fr_byte[k];
      end
      frame_good = req_bus.frame_seen && (fr_sum == 8'd0) && (fr_byte[4] == 8'd0);
      level      = frame_good ? {fr_byte[1], fr_byte[2]} : '0;
      co2_tb     = $signed({2'b00, fr_byte[3]} - CO2_TEMP_BIAS);
      co2_temp   = co2_tb * 16'sd100;

      sample_good = req_bus.voc_ok && (level != '0) && (level != EXCLUDED_PPM) &&
                    (req_bus.tvoc_ppb != TVOC_NONE);

      samp_ext[LANE_HDC_TEMP] = {{(SUM_W-HDC_TEMP_W){req_bus.hdc_temp[HDC_TEMP_W-1]}},
                                 req_bus.hdc_temp};
      samp_ext[LANE_VOC_TEMP] = {{(SUM_W-HDC_TEMP_W){voc_temp_c[HDC_TEMP_W-1]}},
                                 voc_temp_c};
      samp_ext[LANE_CO2_TEMP] = {{(SUM_W-CO2_TEMP_W){co2_temp[CO2_TEMP_W-1]}}, co2_temp};
      samp_ext[LANE_HUMIDITY] = SUM_W'(req_bus.hdc_humidity);
      samp_ext[LANE_CO2]      = SUM_W'(level);
      samp_ext[LANE_ECO2]     = SUM_W'(req_bus.eco2_ppm);
      samp_ext[LANE_TVOC]     = SUM_W'(req_bus.tvoc_ppb);
   end

   // Divider lanes, one quotient bit per cycle.
   always_comb begin
      logic [CNT_W:0] rem_sh;
      logic           ge;
      for (int i = 0; i < NUM_LANES; i++) begin
         rem_sh      = {rem_ff[i], quo_ff[i][SUM_W-1]};
         ge          = rem_sh >= {1'b0, div_ff};
         rem_step[i] = ge ? CNT_W'(rem_sh - {1'b0, div_ff}) : rem_sh[CNT_W-1:0];
         quo_step[i] = {quo_ff[i][SUM_W-2:0], ge};
         lane_res[i] = neg_ff[i] ? -quo_ff[i] : quo_ff[i];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ASVA_IDLE: begin
            if (req_take) begin
               if (req_bus.op == OP_REPORT && count_ff != '0) begin
                  state_in = ASVA_DIV;
               end else begin
                  state_in = ASVA_DONE;
               end
            end
         end
         ASVA_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = ASVA_FIN;
            end
         end
         ASVA_FIN: begin
            state_in = ASVA_DONE;
         end
         ASVA_DONE: begin
            if (load_out) begin
               state_in = ASVA_IDLE;
            end
         end
         default: begin
            state_in = ASVA_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ASVA_IDLE: begin
            req_ready = 1'b1;
         end
         ASVA_DONE: begin
            load_out = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Register next values.
   always_comb begin
      count_in        = count_ff;
      div_in          = div_ff;
      dcnt_in         = dcnt_ff;
      cur_temp_hdc_in = cur_temp_hdc_ff;
      cur_temp_voc_in = cur_temp_voc_ff;
      cur_temp_co2_in = cur_temp_co2_ff;
      cur_humidity_in = cur_humidity_ff;
      cur_co2_in      = cur_co2_ff;
      cur_eco2_in     = cur_eco2_ff;
      cur_tvoc_in     = cur_tvoc_ff;
      cur_valid_in    = cur_valid_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         sum_in[i] = sum_ff[i];
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         neg_in[i] = neg_ff[i];
      end

      if (req_take && req_bus.op == OP_SAMPLE) begin
         cur_temp_hdc_in = req_bus.hdc_temp;
         cur_humidity_in = req_bus.hdc_humidity;
         if (req_bus.voc_ok) begin
            cur_temp_voc_in = voc_temp_c;
            cur_tvoc_in     = req_bus.tvoc_ppb;
            cur_eco2_in     = req_bus.eco2_ppm;
         end else begin
            cur_tvoc_in = TVOC_NONE;
         end
         if (frame_good) begin
            cur_temp_co2_in = co2_temp;
         end
         cur_co2_in = level;
         if (sample_good) begin
            cur_valid_in = 1'b1;
            if (count_ff < CNT_W'(MAX_SAMPLES)) begin
               for (int i = 0; i < NUM_LANES; i++) begin
                  sum_in[i] = sum_ff[i] + samp_ext[i];
               end
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            cur_valid_in = 1'b0;
            count_in     = '0;
            for (int i = 0; i < NUM_LANES; i++) begin
               sum_in[i] = '0;
            end
         end
      end else if (req_take && count_ff != '0) begin
         div_in   = count_ff;
         dcnt_in  = DCNT_W'(SUM_W);
         count_in = '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            neg_in[i] = sum_ff[i][SUM_W-1];
            quo_in[i] = sum_ff[i][SUM_W-1] ? -sum_ff[i] : sum_ff[i];
            rem_in[i] = '0;
            sum_in[i] = '0;
         end
      end

      if (state_ff == ASVA_DIV) begin
         dcnt_in = dcnt_ff - DCNT_W'(1);
         for (int i = 0; i < NUM_LANES; i++) begin
            quo_in[i] = quo_step[i];
            rem_in[i] = rem_step[i];
         end
      end

      if (state_ff == ASVA_FIN) begin
         cur_temp_hdc_in = lane_res[LANE_HDC_TEMP][HDC_TEMP_W-1:0];
         cur_temp_voc_in = lane_res[LANE_VOC_TEMP][HDC_TEMP_W-1:0];
         cur_temp_co2_in = lane_res[LANE_CO2_TEMP][CO2_TEMP_W-1:0];
         cur_humidity_in = lane_res[LANE_HUMIDITY][HUMID_W-1:0];
         cur_co2_in      = lane_res[LANE_CO2][WORD_W-1:0];
         cur_eco2_in     = lane_res[LANE_ECO2][WORD_W-1:0];
         cur_tvoc_in     = lane_res[LANE_TVOC][WORD_W-1:0];
         cur_valid_in    = 1'b1;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      out_temp_hdc_in  = out_temp_hdc_ff;
      out_temp_voc_in  = out_temp_voc_ff;
      out_temp_co2_in  = out_temp_co2_ff;
      out_humidity_in  = out_humidity_ff;
      out_co2_in       = out_co2_ff;
      out_eco2_in      = out_eco2_ff;
      out_tvoc_in      = out_tvoc_ff;
      out_valid_res_in = out_valid_res_ff;
      out_held_in      = out_held_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in     = 1'b1;
         out_temp_hdc_in  = cur_temp_hdc_ff;
         out_temp_voc_in  = cur_temp_voc_ff;
         out_temp_co2_in  = cur_temp_co2_ff;
         out_humidity_in  = cur_humidity_ff;
         out_co2_in       = cur_co2_ff;
         out_eco2_in      = cur_eco2_ff;
         out_tvoc_in      = cur_tvoc_ff;
         out_valid_res_in = cur_valid_ff;
         out_held_in      = HELD_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ASVA_IDLE;
         rsp_valid_ff    <= 1'b0;
         count_ff        <= '0;
         cur_temp_hdc_ff <= '0;
         cur_temp_voc_ff <= '0;
         cur_temp_co2_ff <= '0;
         cur_humidity_ff <= '0;
         cur_co2_ff      <= '0;
         cur_eco2_ff     <= '0;
         cur_tvoc_ff     <= '0;
         cur_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_LANES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         count_ff        <= count_in;
         cur_temp_hdc_ff <= cur_temp_hdc_in;
         cur_temp_voc_ff <= cur_temp_voc_in;
         cur_temp_co2_ff <= cur_temp_co2_in;
         cur_humidity_ff <= cur_humidity_in;
         cur_co2_ff      <= cur_co2_in;
         cur_eco2_ff     <= cur_eco2_in;
         cur_tvoc_ff     <= cur_tvoc_in;
         cur_valid_ff    <= cur_valid_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff           <= div_in;
      dcnt_ff          <= dcnt_in;
      out_temp_hdc_ff  <= out_temp_hdc_in;
      out_temp_voc_ff  <= out_temp_voc_in;
      out_temp_co2_ff  <= out_temp_co2_in;
      out_humidity_ff  <= out_humidity_in;
      out_co2_ff       <= out_co2_in;
      out_eco2_ff      <= out_eco2_in;
      out_tvoc_ff      <= out_tvoc_in;
      out_valid_res_ff <= out_valid_res_in;
      out_held_ff      <= out_held_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.temp_hdc     = out_temp_hdc_ff;
   assign rsp_bus.temp_voc     = out_temp_voc_ff;
   assign rsp_bus.temp_co2     = out_temp_co2_ff;
   assign rsp_bus.humidity     = out_humidity_ff;
   assign rsp_bus.co2_ppm      = out_co2_ff;
   assign rsp_bus.eco2         = out_eco2_ff;
   assign rsp_bus.tvoc         = out_tvoc_ff;
   assign rsp_bus.valid_res    = out_valid_res_ff;
   assign rsp_bus.samples_held = out_held_ff;

`include "air_sensor_validate_and_average_unit_assert.svh"

   `ASVA_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_SAMPLES), "sample count above limit")
   `ASVA_ASSERT(a_div_clean, clock, reset, (state_ff == ASVA_DIV) |-> (count_ff == '0 && div_ff != '0), "division with live sums or zero divisor")
   `ASVA_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != ASVA_IDLE, "accepted beat left no work")
   `ASVA_ASSERT_NEXT(a_fin_valid, clock, reset, state_ff == ASVA_FIN, cur_valid_ff, "report did not set valid flag")

endmodule
